// ----- src/nsh_pkg.sv -----
// Package for the nearest segment hit block: sizes, codes, state encoding
// and the structs passed between the cells, the test pipeline and the tracker.
// Depends on nothing; every other file imports it.
package nsh_pkg;

  localparam int MAX_WALLS = 64;
  localparam int SLOT_W    = $clog2(MAX_WALLS);
  localparam int CNT_W     = 7;
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int HALF_W    = MAG_W / 2;
  localparam int WIDE_W    = 2 * MAG_W;
  localparam int T_W       = 32;
  localparam int T_OUT_W   = 16;
  localparam int DIV_CNT_W = $clog2(T_W);
  localparam int PT_W      = DIFF_W + T_W + 1;
  localparam int DRAIN_CYC = 6;
  localparam int MERGE_CYC = 3;
  localparam int STEP_W    = $clog2(MAX_WALLS + DRAIN_CYC + MERGE_CYC);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CAST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MERGE,
    ST_DIV,
    ST_POINT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } wall_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } ray_t;

  typedef struct packed {
    logic              valid;
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [SLOT_W-1:0] slot;
  } cand_t;

  typedef struct packed {
    logic              found;
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic [SLOT_W-1:0] slot;
  } best_t;

  typedef struct packed {
    logic clear;
    logic merge;
  } bt_ctl_t;

endpackage

// ----- src/nsh_if.sv -----
// Channel interfaces of the nearest segment hit block: input items, results
// and the wall count register write. Depends on nsh_pkg.
interface nsh_in_if import nsh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [SLOT_W-1:0]         wall_slot;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  modport source(output valid, func, wall_slot, start_x, start_y, end_x, end_y,
                 input ready);
  modport sink(input valid, func, wall_slot, start_x, start_y, end_x, end_y,
               output ready);
endinterface

interface nsh_out_if import nsh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [COORD_W-1:0] hit_x;
  logic signed [COORD_W-1:0] hit_y;
  logic [T_OUT_W-1:0]        hit_t;
  logic [SLOT_W-1:0]         hit_wall;
  modport source(output valid, hit, hit_x, hit_y, hit_t, hit_wall, input ready);
  modport sink(input valid, hit, hit_x, hit_y, hit_t, hit_wall, output ready);
endinterface

interface nsh_cfg_if import nsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] wall_count;
  modport source(output valid, wall_count, input ready);
  modport sink(input valid, wall_count, output ready);
endinterface

// ----- src/nsh_wall_cell.sv -----
// One cell of the wall ring: holds one wall and takes its neighbor's wall
// when the ring rotates. Depends on nsh_pkg.
module nsh_wall_cell import nsh_pkg::*; (
  input  logic  clk,
  input  logic  load_en,
  input  wall_t load_wall,
  input  logic  shift_en,
  input  wall_t next_wall,
  output wall_t wall
);

  wall_t wall_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      wall_r <= load_wall;
    end else if (shift_en) begin
      wall_r <= next_wall;
    end
  end

  assign wall = wall_r;

endmodule

// ----- src/nsh_hit_test.sv -----
// Four-stage pipeline that tests one wall per cycle against the ray with
// cross products and emits the hit as the fraction num/den. Depends on nsh_pkg.
module nsh_hit_test import nsh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ray_t              ray,
  input  wall_t             wall,
  input  logic              in_valid,
  input  logic [SLOT_W-1:0] in_slot,
  output cand_t             cand
);

  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  logic [SLOT_W-1:0]        s1_slot_r, s2_slot_r, s3_slot_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, wx_r, wy_r;
  logic signed [PROD_W-1:0] p_duy_r, p_dyux_r, p_wxuy_r, p_wyux_r, p_wxdy_r, p_wydx_r;
  logic signed [CROSS_W-1:0] b_r, a1_r, a2_r;
  logic signed [CROSS_W-1:0] bn, a1n, a2n;
  logic                      ok;
  cand_t                     cand_nxt;
  logic                      cand_valid_r;
  logic [MAG_W-1:0]          cand_num_r, cand_den_r;
  logic [SLOT_W-1:0]         cand_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      cand_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= in_valid;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      cand_valid_r <= cand_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot_r <= in_slot;
    ux_r      <= DIFF_W'(wall.bx) - DIFF_W'(wall.ax);
    uy_r      <= DIFF_W'(wall.by) - DIFF_W'(wall.ay);
    wx_r      <= DIFF_W'(wall.ax) - DIFF_W'(ray.sx);
    wy_r      <= DIFF_W'(wall.ay) - DIFF_W'(ray.sy);

    s2_slot_r <= s1_slot_r;
    p_duy_r   <= ray.dx * uy_r;
    p_dyux_r  <= ray.dy * ux_r;
    p_wxuy_r  <= wx_r * uy_r;
    p_wyux_r  <= wy_r * ux_r;
    p_wxdy_r  <= wx_r * ray.dy;
    p_wydx_r  <= wy_r * ray.dx;

    s3_slot_r <= s2_slot_r;
    b_r       <= CROSS_W'(p_duy_r) - CROSS_W'(p_dyux_r);
    a1_r      <= CROSS_W'(p_wxuy_r) - CROSS_W'(p_wyux_r);
    a2_r      <= CROSS_W'(p_wxdy_r) - CROSS_W'(p_wydx_r);

    cand_num_r  <= cand_nxt.num;
    cand_den_r  <= cand_nxt.den;
    cand_slot_r <= cand_nxt.slot;
  end

  // Flip signs so the denominator is positive, then require t in [0,1) and u in [0,1].
  always_comb begin
    bn  = b_r[CROSS_W-1] ? -b_r  : b_r;
    a1n = b_r[CROSS_W-1] ? -a1_r : a1_r;
    a2n = b_r[CROSS_W-1] ? -a2_r : a2_r;
    ok  = (b_r != '0) && !a1n[CROSS_W-1] && (a1n < bn) && !a2n[CROSS_W-1] && (a2n <= bn);
    cand_nxt.valid = s3_valid_r && ok;
    cand_nxt.num   = a1n[MAG_W-1:0];
    cand_nxt.den   = bn[MAG_W-1:0];
    cand_nxt.slot  = s3_slot_r;
  end

  assign cand = '{valid: cand_valid_r, num: cand_num_r, den: cand_den_r, slot: cand_slot_r};

endmodule

// ----- src/nsh_best_track.sv -----
// Keeps the smallest hit fraction with an exact cross-multiplied compare.
// Even and odd slots have separate bests so a wall can arrive every cycle;
// the merge step folds the odd best into the even one. Depends on nsh_pkg.
module nsh_best_track import nsh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  bt_ctl_t ctl,
  input  cand_t   cand,
  output best_t   best
);

  typedef struct packed {
    logic [2*HALF_W-1:0] ll;
    logic [2*HALF_W-1:0] lh;
    logic [2*HALF_W-1:0] hl;
    logic [2*HALF_W-1:0] hh;
  } parts_t;

  function automatic parts_t mul_parts(input logic [MAG_W-1:0] a, input logic [MAG_W-1:0] b);
    parts_t p;
    p.ll = a[HALF_W-1:0] * b[HALF_W-1:0];
    p.lh = a[HALF_W-1:0] * b[MAG_W-1:HALF_W];
    p.hl = a[MAG_W-1:HALF_W] * b[HALF_W-1:0];
    p.hh = a[MAG_W-1:HALF_W] * b[MAG_W-1:HALF_W];
    return p;
  endfunction

  function automatic logic [WIDE_W-1:0] join_parts(input parts_t p);
    logic [WIDE_W-1:0] mid;
    mid = WIDE_W'(p.lh) + WIDE_W'(p.hl);
    return (WIDE_W'(p.hh) << (2 * HALF_W)) + (mid << HALF_W) + WIDE_W'(p.ll);
  endfunction

  localparam best_t BEST_INIT = '{found: 1'b0, num: MAG_W'(1), den: MAG_W'(1), slot: '0};

  best_t             best0_r, best1_r;
  best_t             sel_in, sel_c;
  logic              in_v, in_par;
  logic [MAG_W-1:0]  in_num, in_den;
  logic [SLOT_W-1:0] in_slot;
  logic              p_valid_r, p_par_r;
  logic [MAG_W-1:0]  p_num_r, p_den_r;
  logic [SLOT_W-1:0] p_slot_r;
  parts_t            lhs_r, rhs_r;
  logic [WIDE_W-1:0] lhs, rhs;
  logic              less;

  always_comb begin
    if (ctl.merge) begin
      in_v    = best1_r.found;
      in_par  = 1'b0;
      in_num  = best1_r.num;
      in_den  = best1_r.den;
      in_slot = best1_r.slot;
    end else begin
      in_v    = cand.valid;
      in_par  = cand.slot[0];
      in_num  = cand.num;
      in_den  = cand.den;
      in_slot = cand.slot;
    end
    sel_in = in_par  ? best1_r : best0_r;
    sel_c  = p_par_r ? best1_r : best0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_v && !ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    p_par_r  <= in_par;
    p_num_r  <= in_num;
    p_den_r  <= in_den;
    p_slot_r <= in_slot;
    lhs_r    <= mul_parts(in_num, sel_in.den);
    rhs_r    <= mul_parts(sel_in.num, in_den);
  end

  // On equal fractions the lower slot wins, which only matters at the merge.
  always_comb begin
    lhs  = join_parts(lhs_r);
    rhs  = join_parts(rhs_r);
    less = (lhs < rhs) || ((lhs == rhs) && (p_slot_r < sel_c.slot));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      best0_r <= BEST_INIT;
      best1_r <= BEST_INIT;
    end else if (p_valid_r && less) begin
      if (p_par_r) begin
        best1_r <= '{found: 1'b1, num: p_num_r, den: p_den_r, slot: p_slot_r};
      end else begin
        best0_r <= '{found: 1'b1, num: p_num_r, den: p_den_r, slot: p_slot_r};
      end
    end
  end

  assign best = best0_r;

endmodule

// ----- src/nsh_divider.sv -----
// Restoring long division of a proper fraction num/den into a 32-bit
// binary fraction, one quotient bit per cycle. Depends on nsh_pkg.
module nsh_divider import nsh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] num,
  input  logic [MAG_W-1:0] den,
  output logic             done,
  output logic [T_W-1:0]   quo
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0]     rem_r, den_r;
  logic [T_W-1:0]       quo_r;
  logic [MAG_W:0]       rem2;
  logic                 ge;

  always_comb begin
    rem2 = {rem_r, 1'b0};
    ge   = rem2 >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(T_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? MAG_W'(rem2 - {1'b0, den_r}) : rem2[MAG_W-1:0];
      quo_r <= {quo_r[T_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- src/nearest_segment_hit.sv -----
// A load item writes one wall into the ring of wall cells and gives no result.
// A cast rotates the ring once around, passing the first wall-count walls into
// the cross product pipeline one wall per cycle, waits in the drain state for
// the pipeline and the best tracker to empty, merges the even and odd bests,
// then, if a wall was hit, runs the bit-serial divider and forms the hit point.
// A result waits in the output register while loads and the next cast are taken.
// Depends on nsh_pkg, the channel interfaces and the nsh_* submodules.
module nearest_segment_hit import nsh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nsh_cfg_if.sink    cfg_ch,
  nsh_in_if.sink     in_ch,
  nsh_out_if.source  out_ch
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  wall_count_r, n_eff;
  ray_t              ray_r;
  wall_t             load_wall;
  wall_t             cell_wall [MAX_WALLS];
  logic              in_acc, cast_acc, load_acc, last;
  logic              shift_en, scan_valid, div_start, out_load, out_free;
  bt_ctl_t           bt_ctl;
  cand_t             cand;
  best_t             best;
  logic              div_done;
  logic [T_W-1:0]    quo;
  logic signed [PT_W-1:0] prod_x_r, prod_y_r, sum_x, sum_y, hx, hy;

  logic                      out_valid_r, out_hit_r;
  logic signed [COORD_W-1:0] out_hit_x_r, out_hit_y_r;
  logic [T_OUT_W-1:0]        out_hit_t_r;
  logic [SLOT_W-1:0]         out_hit_wall_r;

  assign cfg_ch.ready = 1'b1;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cast_acc = in_acc && (in_ch.func == FUNC_CAST);
  assign load_acc = in_acc && (in_ch.func == FUNC_LOAD);
  assign out_free = !out_valid_r || out_ch.ready;
  assign n_eff    = (wall_count_r > CNT_W'(MAX_WALLS)) ? CNT_W'(MAX_WALLS) : wall_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_count_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      wall_count_r <= cfg_ch.wall_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cast_acc) begin
      ray_r.sx <= in_ch.start_x;
      ray_r.sy <= in_ch.start_y;
      ray_r.dx <= DIFF_W'(in_ch.end_x) - DIFF_W'(in_ch.start_x);
      ray_r.dy <= DIFF_W'(in_ch.end_y) - DIFF_W'(in_ch.start_y);
    end
  end

  // Ring of wall cells; cell zero feeds the test pipeline and takes from cell one.
  assign load_wall = '{ax: in_ch.start_x, ay: in_ch.start_y, bx: in_ch.end_x, by: in_ch.end_y};

  for (genvar k = 0; k < MAX_WALLS; k++) begin : g_cell
    nsh_wall_cell u_cell (
      .clk       (clk),
      .load_en   (load_acc && (in_ch.wall_slot == SLOT_W'(k))),
      .load_wall (load_wall),
      .shift_en  (shift_en),
      .next_wall (cell_wall[(k + 1) % MAX_WALLS]),
      .wall      (cell_wall[k])
    );
  end

  nsh_hit_test u_test (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .wall     (cell_wall[0]),
    .in_valid (scan_valid),
    .in_slot  (step_r[SLOT_W-1:0]),
    .cand     (cand)
  );

  nsh_best_track u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bt_ctl),
    .cand  (cand),
    .best  (best)
  );

  nsh_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (best.num),
    .den   (best.den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cast_acc) state_nxt = ST_SCAN;
      ST_SCAN:  if (step_r == STEP_W'(MAX_WALLS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: if (step_r == STEP_W'(DRAIN_CYC - 1)) state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (step_r == STEP_W'(MERGE_CYC - 1)) begin
          state_nxt = best.found ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_POINT;
      ST_POINT: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    step_nxt = (state_nxt != state_r) ? '0 : step_r + 1'b1;
  end

  always_comb begin
    last = (step_r == STEP_W'(MERGE_CYC - 1));
    in_ch.ready  = (state_r == ST_IDLE);
    shift_en     = (state_r == ST_SCAN);
    scan_valid   = (state_r == ST_SCAN) && ({1'b0, step_r} < (STEP_W + 1)'(n_eff));
    bt_ctl.clear = cast_acc;
    bt_ctl.merge = (state_r == ST_MERGE) && (step_r == '0);
    div_start    = (state_r == ST_MERGE) && last && best.found;
    out_load     = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_POINT) begin
      prod_x_r <= PT_W'(ray_r.dx) * PT_W'(signed'({1'b0, quo}));
      prod_y_r <= PT_W'(ray_r.dy) * PT_W'(signed'({1'b0, quo}));
    end
  end

  // Round to nearest with ties up: add one half, then floor by arithmetic shift.
  always_comb begin
    sum_x = prod_x_r + PT_W'(64'd1 << (T_W - 1));
    sum_y = prod_y_r + PT_W'(64'd1 << (T_W - 1));
    hx    = PT_W'(ray_r.sx) + (sum_x >>> T_W);
    hy    = PT_W'(ray_r.sy) + (sum_y >>> T_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r      <= best.found;
      out_hit_x_r    <= best.found ? hx[COORD_W-1:0] : '0;
      out_hit_y_r    <= best.found ? hy[COORD_W-1:0] : '0;
      out_hit_t_r    <= best.found ? quo[T_W-1 -: T_OUT_W] : '0;
      out_hit_wall_r <= best.found ? best.slot : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = out_hit_r;
  assign out_ch.hit_x    = out_hit_x_r;
  assign out_ch.hit_y    = out_hit_y_r;
  assign out_ch.hit_t    = out_hit_t_r;
  assign out_ch.hit_wall = out_hit_wall_r;

  a_cast_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cast_acc |=> (state_r == ST_SCAN) && (step_r == '0))
    else $error("cast transfer did not start the scan");

  a_drained_before_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !cand.valid)
    else $error("hit candidate still in flight during division");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division state");

  a_point_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POINT) |-> best.found)
    else $error("hit point formed without a recorded hit");

  a_result_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_ch.valid)
    else $error("finished cast did not present a result");

endmodule
